[design/ssvg_pkg.sv]
// ----------------------------------------------------------------------------
// ssvg_pkg
// Shared constants and helper functions for the sphere strip vertex generator.
// ----------------------------------------------------------------------------
package ssvg_pkg;

    typedef enum logic [0:0] {
        REG_SLICE_COUNT = 1'b0,
        REG_RADIUS_Q8   = 1'b1
    } ssvg_reg_t;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam int PHASE_W   = 16;
    localparam int QUARTER   = 16384;
    localparam int SINE_MAX  = 32767;
    localparam int COORD_W   = 17;
    localparam int TRIG_W    = 16;
    localparam int RAD_W     = 16;
    localparam int PROD_W    = 33;
    localparam int XY_W      = 49;

    localparam longint unsigned SINE_DIVS [6] = '{64'd156, 64'd110, 64'd72,
                                                  64'd42, 64'd20, 64'd6};

    // Horner series of sin in Q30, rounded to Q15 and capped
    function automatic logic [14:0] sine_from_x(input longint unsigned x);
        longint unsigned x2;
        longint unsigned f;
        longint unsigned s;
        longint unsigned q;
        x2 = (x * x) >> 30;
        f  = Q30_ONE;
        for (int n = 0; n < 6; n++) begin
            f = Q30_ONE - ((x2 * f) >> 30) / SINE_DIVS[n];
        end
        s = (x * f) >> 30;
        q = (s + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[14:0];
    endfunction

    // Round Q30 product to nearest, ties away from zero
    function automatic logic [COORD_W-1:0] round_xy(input logic signed [XY_W-1:0] p);
        logic [XY_W-1:0] mag;
        logic [XY_W-1:0] r;
        logic [XY_W-1:0] v;
        mag = p[XY_W-1] ? (~p + 1'b1) : p;
        r   = (mag + (XY_W'(1) << 29)) >> 30;
        v   = p[XY_W-1] ? (~r + 1'b1) : r;
        return v[COORD_W-1:0];
    endfunction

    // Round Q15 product to nearest, ties away from zero
    function automatic logic [COORD_W-1:0] round_z(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] r;
        logic [PROD_W-1:0] v;
        mag = p[PROD_W-1] ? (~p + 1'b1) : p;
        r   = (mag + (PROD_W'(1) << 14)) >> 15;
        v   = p[PROD_W-1] ? (~r + 1'b1) : r;
        return v[COORD_W-1:0];
    endfunction

endpackage

[design/sphere_strip_vertex_generator.sv]
// Pipeline: input register, bit-per-stage phase dividers, lookup registers l1 and
//   l2, scaling registers m1 and m2, then the output register.
// Throughput: one beat per cycle while not stalled; the bit-per-stage phase dividers set the depth.
// Backpressure stalls the whole pipeline in place.
// Reset: rst_n clears all valid bits; slice_count resets to 16, radius_q8 to 256.
// ----------------------------------------------------------------------------
// sphere_strip_vertex_generator
// Pipelined UV-sphere quad-strip vertex generator: phase division, quarter-wave
// sine lookup, radius scaling and rounding.
// ----------------------------------------------------------------------------
module sphere_strip_vertex_generator #(
    parameter int MAX_SLICES       = 64,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [6:0]                     band_index,
    input  logic [6:0]                     meridian_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [16:0]             lower_x,
    output logic signed [16:0]             lower_y,
    output logic signed [16:0]             lower_z,
    output logic signed [16:0]             upper_x,
    output logic signed [16:0]             upper_y,
    output logic signed [16:0]             upper_z
);
    import ssvg_pkg::*;

    localparam int SW  = $clog2(MAX_SLICES + 1);
    localparam int AW  = $clog2(127 + MAX_SLICES + 1);
    localparam int NW  = AW + 16;
    localparam int D   = SINE_TABLE_DEPTH;
    localparam int IW  = $clog2(D);
    localparam int PRW = 15 + $clog2(D + 1);
    localparam int XW  = PRW - 14;
    localparam int ST_OUT = NW + 5;
    localparam int NST    = NW + 6;

    // configuration
    logic [6:0]      slice_count_reg;
    logic [RAD_W-1:0] radius_q8_reg;
    logic [SW-1:0]   s_eff;
    logic            cfg_wr;
    ssvg_reg_t       cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = ssvg_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_count_reg <= 7'd16;
            radius_q8_reg   <= 16'd256;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_SLICE_COUNT: slice_count_reg <= pwdata[6:0];
                REG_RADIUS_Q8:   radius_q8_reg   <= pwdata[15:0];
                default:         slice_count_reg <= slice_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_SLICE_COUNT: prdata = 32'(slice_count_reg);
            REG_RADIUS_Q8:   prdata = 32'(radius_q8_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        if (slice_count_reg == 7'd0)
        begin
            s_eff = SW'(1);
        end
        else if (32'(slice_count_reg) > MAX_SLICES)
        begin
            s_eff = SW'(MAX_SLICES);
        end
        else
        begin
            s_eff = SW'(slice_count_reg);
        end
    end

    // pipeline control
    logic [NST-1:0] vld_reg;
    logic           adv;

    assign adv       = !vld_reg[ST_OUT] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // phase dividers: lane 0 lower ring, lane 1 upper ring, lane 2 longitude
    logic [NW-1:0] dnum_reg [NW+1][3];
    logic [SW-1:0] drem_reg [NW+1][3];
    logic [15:0]   dquo_reg [NW+1][3];
    logic [AW-1:0] a_lane [3];
    logic [NW-1:0] n_lane [3];

    always_comb
    begin
        a_lane[0] = AW'(band_index) + AW'(s_eff) - AW'(1);
        a_lane[1] = AW'(band_index) + AW'(s_eff);
        a_lane[2] = AW'(meridian_index) + AW'(s_eff) - AW'(1);
        n_lane[0] = (NW'(a_lane[0]) << 15) | NW'(s_eff >> 1);
        n_lane[1] = (NW'(a_lane[1]) << 15) | NW'(s_eff >> 1);
        n_lane[2] = (NW'(a_lane[2]) << 16) | NW'(s_eff >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                dnum_reg[0][l] <= n_lane[l];
                drem_reg[0][l] <= '0;
                dquo_reg[0][l] <= '0;
            end
        end
    end

    for (genvar i = 0; i < NW; i++) begin : g_div
        logic [SW:0]   trial [3];
        logic          ge    [3];
        logic [SW:0]   diff  [3];

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[l] = {drem_reg[i][l], dnum_reg[i][l][NW-1]};
                ge[l]    = trial[l] >= {1'b0, s_eff};
                diff[l]  = ge[l] ? (trial[l] - {1'b0, s_eff}) : trial[l];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    dnum_reg[i+1][l] <= dnum_reg[i][l] << 1;
                    drem_reg[i+1][l] <= diff[l][SW-1:0];
                    dquo_reg[i+1][l] <= {dquo_reg[i][l][14:0], ge[l]};
                end
            end
        end
    end

    // quarter-wave table
    logic [14:0] sine_rom [D];

    for (genvar i = 0; i < D; i++) begin : g_rom
        localparam longint unsigned X =
            (longint'(i) * HALF_PI_Q30 + longint'(D / 2)) / longint'(D);
        assign sine_rom[i] = sine_from_x(X);
    end

    // lookup: cos lon, sin lon, cos/sin lower lat, cos/sin upper lat
    logic [PHASE_W-1:0] ph [6];
    logic [PHASE_W-1:0] q_lo;
    logic [PHASE_W-1:0] q_up;
    logic [PHASE_W-1:0] q_lon;
    logic [14:0]        u_val [6];
    logic [PRW-1:0]     u_prod [6];
    logic [XW-1:0]      idx_full [6];

    logic [IW-1:0] l1_idx_reg [6];
    logic          l1_sat_reg [6];
    logic          l1_neg_reg [6];
    logic [14:0]   l2_mag_reg [6];
    logic          l2_neg_reg [6];

    always_comb
    begin
        q_lo  = dquo_reg[NW][0] + PHASE_W'(QUARTER);
        q_up  = dquo_reg[NW][1] + PHASE_W'(QUARTER);
        q_lon = dquo_reg[NW][2];
        ph[0] = q_lon + PHASE_W'(QUARTER);
        ph[1] = q_lon;
        ph[2] = q_lo + PHASE_W'(QUARTER);
        ph[3] = q_lo;
        ph[4] = q_up + PHASE_W'(QUARTER);
        ph[5] = q_up;
        for (int n = 0; n < 6; n++)
        begin
            u_val[n]    = ph[n][14] ? (15'(QUARTER) - {1'b0, ph[n][13:0]})
                                    : {1'b0, ph[n][13:0]};
            u_prod[n]   = PRW'(u_val[n]) * PRW'(D);
            idx_full[n] = u_prod[n][PRW-1:14];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int n = 0; n < 6; n++)
            begin
                l1_idx_reg[n] <= idx_full[n][IW-1:0];
                l1_sat_reg[n] <= 32'(idx_full[n]) >= D;
                l1_neg_reg[n] <= ph[n][15];
                l2_mag_reg[n] <= l1_sat_reg[n] ? 15'(SINE_MAX) : sine_rom[l1_idx_reg[n]];
                l2_neg_reg[n] <= l1_neg_reg[n];
            end
        end
    end

    // scaling
    logic signed [TRIG_W-1:0] trig [6];
    logic signed [RAD_W:0]    rad_s;

    logic signed [TRIG_W-1:0] m1_cl_reg;
    logic signed [TRIG_W-1:0] m1_sl_reg;
    logic signed [PROD_W-1:0] m1_pl_lo_reg;
    logic signed [PROD_W-1:0] m1_pl_up_reg;
    logic signed [PROD_W-1:0] m1_z_lo_reg;
    logic signed [PROD_W-1:0] m1_z_up_reg;

    logic signed [XY_W-1:0]   m2_x_lo_reg;
    logic signed [XY_W-1:0]   m2_y_lo_reg;
    logic signed [XY_W-1:0]   m2_x_up_reg;
    logic signed [XY_W-1:0]   m2_y_up_reg;
    logic signed [PROD_W-1:0] m2_z_lo_reg;
    logic signed [PROD_W-1:0] m2_z_up_reg;

    always_comb
    begin
        rad_s = signed'({1'b0, radius_q8_reg});
        for (int n = 0; n < 6; n++)
        begin
            trig[n] = l2_neg_reg[n] ? -signed'({1'b0, l2_mag_reg[n]})
                                    : signed'({1'b0, l2_mag_reg[n]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_cl_reg    <= trig[0];
            m1_sl_reg    <= trig[1];
            m1_pl_lo_reg <= PROD_W'(trig[2] * rad_s);
            m1_z_lo_reg  <= PROD_W'(trig[3] * rad_s);
            m1_pl_up_reg <= PROD_W'(trig[4] * rad_s);
            m1_z_up_reg  <= PROD_W'(trig[5] * rad_s);

            m2_x_lo_reg  <= XY_W'(m1_cl_reg * m1_pl_lo_reg);
            m2_y_lo_reg  <= XY_W'(m1_sl_reg * m1_pl_lo_reg);
            m2_x_up_reg  <= XY_W'(m1_cl_reg * m1_pl_up_reg);
            m2_y_up_reg  <= XY_W'(m1_sl_reg * m1_pl_up_reg);
            m2_z_lo_reg  <= m1_z_lo_reg;
            m2_z_up_reg  <= m1_z_up_reg;

            lower_x <= round_xy(m2_x_lo_reg);
            lower_y <= round_xy(m2_y_lo_reg);
            lower_z <= round_z(m2_z_lo_reg);
            upper_x <= round_xy(m2_x_up_reg);
            upper_y <= round_xy(m2_y_up_reg);
            upper_z <= round_z(m2_z_up_reg);
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_sat_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && l1_sat_reg[0]) |=> (l2_mag_reg[0] == 15'(SINE_MAX)))
        else $error("saturated lookup did not read full scale");

    a_out_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(adv))
        else $error("output beat appeared without a pipeline advance");
`endif

endmodule
